// ===== design/lcg48br_pkg.sv =====
package lcg48br_pkg;

    localparam int SEED_W  = 48;
    localparam int DRAW_W  = 31;
    localparam int MULT_W  = 35;
    localparam int CNT_W   = 5;

    localparam logic [MULT_W-1:0] LCG_MULT = 35'h5_DEEC_E66D;
    localparam logic [SEED_W-1:0] LCG_INC  = 48'hB;

    // Request codes
    localparam logic [1:0] FUNC_RESEED  = 2'd0;
    localparam logic [1:0] FUNC_RAW     = 2'd1;
    localparam logic [1:0] FUNC_BOUNDED = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADV_LO,
        ST_ADV_HI,
        ST_RAW,
        ST_POW,
        ST_DIV_INIT,
        ST_DIV,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic adv_lo;
        logic adv_hi;
        logic raw_out;
        logic pow_out;
        logic div_init;
        logic div_step;
        logic rem_out;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       pow2;
        logic       div_last;
        logic       reject;
    } status_t;

endpackage

// ===== design/lcg48br_ctrl.sv =====
module lcg48br_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1:0]             func,
    input  lcg48br_pkg::status_t   status,
    output lcg48br_pkg::cmd_t      cmd,
    output logic                   busy,
    output logic                   done
);

    lcg48br_pkg::state_t state_reg;
    lcg48br_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcg48br_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcg48br_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (func == lcg48br_pkg::FUNC_RAW || func == lcg48br_pkg::FUNC_BOUNDED)
                    begin
                        state_next = lcg48br_pkg::ST_ADV_LO;
                    end
                    else
                    begin
                        state_next = lcg48br_pkg::ST_DONE;
                    end
                end
            end
            lcg48br_pkg::ST_ADV_LO:
            begin
                state_next = lcg48br_pkg::ST_ADV_HI;
            end
            lcg48br_pkg::ST_ADV_HI:
            begin
                if (status.func == lcg48br_pkg::FUNC_RAW)
                begin
                    state_next = lcg48br_pkg::ST_RAW;
                end
                else if (status.pow2)
                begin
                    state_next = lcg48br_pkg::ST_POW;
                end
                else
                begin
                    state_next = lcg48br_pkg::ST_DIV_INIT;
                end
            end
            lcg48br_pkg::ST_RAW:
            begin
                state_next = lcg48br_pkg::ST_DONE;
            end
            lcg48br_pkg::ST_POW:
            begin
                state_next = lcg48br_pkg::ST_DONE;
            end
            lcg48br_pkg::ST_DIV_INIT:
            begin
                state_next = lcg48br_pkg::ST_DIV;
            end
            lcg48br_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = lcg48br_pkg::ST_CHECK;
                end
            end
            lcg48br_pkg::ST_CHECK:
            begin
                // redraw on rejection
                if (status.reject)
                begin
                    state_next = lcg48br_pkg::ST_ADV_LO;
                end
                else
                begin
                    state_next = lcg48br_pkg::ST_DONE;
                end
            end
            lcg48br_pkg::ST_DONE:
            begin
                state_next = lcg48br_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lcg48br_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            lcg48br_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            lcg48br_pkg::ST_ADV_LO:   cmd.adv_lo   = 1'b1;
            lcg48br_pkg::ST_ADV_HI:   cmd.adv_hi   = 1'b1;
            lcg48br_pkg::ST_RAW:      cmd.raw_out  = 1'b1;
            lcg48br_pkg::ST_POW:      cmd.pow_out  = 1'b1;
            lcg48br_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
            lcg48br_pkg::ST_DIV:      cmd.div_step = 1'b1;
            lcg48br_pkg::ST_CHECK:    cmd.rem_out  = 1'b1;
            lcg48br_pkg::ST_DONE:     done         = 1'b1;
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== design/lcg48br_dp.sv =====
module lcg48br_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lcg48br_pkg::cmd_t                   cmd,
    input  logic [1:0]                          func,
    input  logic [63:0]                         seed_value,
    input  logic [4:0]                          bit_count,
    input  logic [lcg48br_pkg::DRAW_W-1:0]      bound,
    output lcg48br_pkg::status_t                status,
    output logic [lcg48br_pkg::DRAW_W-1:0]      value,
    output logic [lcg48br_pkg::SEED_W-1:0]      seed_after
);

    localparam int SW = lcg48br_pkg::SEED_W;
    localparam int DW = lcg48br_pkg::DRAW_W;
    localparam int MW = lcg48br_pkg::MULT_W;
    localparam int HW = SW / 2;

    logic [SW-1:0]                   seed_reg;
    logic [SW-1:0]                   acc_reg;
    logic [1:0]                      func_reg;
    logic [4:0]                      bit_count_reg;
    logic [DW-1:0]                   bound_reg;
    logic [DW-1:0]                   bits_reg;
    logic [DW-1:0]                   dvd_reg;
    logic [DW-1:0]                   rem_reg;
    logic [DW-1:0]                   value_reg;
    logic [lcg48br_pkg::CNT_W-1:0]   cnt_reg;

    logic [HW+MW-1:0]  prod_lo;
    logic [SW-1:0]     prod_hi;
    logic [SW-1:0]     seed_adv;
    logic [5:0]        raw_shift;
    logic [SW-1:0]     raw_bits;
    logic [2*DW-1:0]   pow_prod;
    logic [DW:0]       partial;
    logic [DW+1:0]     diff;
    logic [DW-1:0]     rem_step;
    logic [DW:0]       accept_sum;

    // Low half of the seed times the full multiplier; only 48 bits survive
    assign prod_lo = {{MW{1'b0}}, seed_reg[HW-1:0]} * {{HW{1'b0}}, lcg48br_pkg::LCG_MULT};
    // High half only reaches bits 24..47 through the low 24 multiplier bits
    assign prod_hi = {{HW{1'b0}}, seed_reg[SW-1:HW]}
                   * {{HW{1'b0}}, lcg48br_pkg::LCG_MULT[HW-1:0]};
    assign seed_adv = acc_reg + {prod_hi[HW-1:0], {HW{1'b0}}} + lcg48br_pkg::LCG_INC;

    assign raw_shift = 6'(SW) - {1'b0, bit_count_reg};
    assign raw_bits  = seed_reg >> raw_shift;

    assign pow_prod = {{DW{1'b0}}, bound_reg} * {{DW{1'b0}}, bits_reg};

    // One restoring division step: remainder only
    assign partial  = {rem_reg, dvd_reg[DW-1]};
    assign diff     = {1'b0, partial} - {2'b00, bound_reg};
    assign rem_step = diff[DW+1] ? partial[DW-1:0] : diff[DW-1:0];

    // 32-bit wrapped bits - val + (bound - 1); sign bit means redraw
    assign accept_sum = {1'b0, bits_reg} - {1'b0, rem_reg} + {1'b0, bound_reg} - 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.capture && func == lcg48br_pkg::FUNC_RESEED)
            begin
                seed_reg <= seed_value[SW-1:0] ^ {{(SW-MW){1'b0}}, lcg48br_pkg::LCG_MULT};
            end
            else if (cmd.adv_hi)
            begin
                seed_reg <= seed_adv;
            end
            if (cmd.div_init)
            begin
                cnt_reg <= lcg48br_pkg::CNT_W'(DW - 1);
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - lcg48br_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg      <= func;
            bit_count_reg <= bit_count;
            bound_reg     <= bound;
            value_reg     <= '0;
        end
        if (cmd.adv_lo)
        begin
            acc_reg <= prod_lo[SW-1:0];
        end
        if (cmd.adv_hi)
        begin
            bits_reg <= seed_adv[SW-1:SW-DW];
        end
        if (cmd.raw_out)
        begin
            value_reg <= raw_bits[DW-1:0];
        end
        if (cmd.pow_out)
        begin
            value_reg <= pow_prod[2*DW-1:DW];
        end
        if (cmd.div_init)
        begin
            dvd_reg <= bits_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            rem_reg <= rem_step;
        end
        if (cmd.rem_out)
        begin
            value_reg <= rem_reg;
        end
    end

    assign status.func     = func_reg;
    assign status.pow2     = ((bound_reg & (bound_reg - DW'(1))) == '0);
    assign status.div_last = (cnt_reg == '0);
    assign status.reject   = accept_sum[DW];

    assign value      = value_reg;
    assign seed_after = seed_reg;

endmodule

// ===== design/lcg48_bounded_random.sv =====
// 48-bit LCG (multiplier 0x5DEECE66D, increment 0xB) with reseed, raw draw
// and bounded draw requests. Raise start while busy is low to hand over one
// item; done pulses for exactly one cycle with value and seed_after, and the
// receiver cannot stall, so capture them on that edge. Reseed and the unused
// code 3 go straight to done; a raw draw and a power-of-two bounded draw
// advance the seed and then extract; any other bounded draw runs the
// 31-step restoring remainder unit, and each rejected draw repeats the seed
// advance and the division. The seed advance forms its 24-bit partial
// products in the ADV_LO and ADV_HI states.
module lcg48_bounded_random (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         func,
    input  logic [63:0]                        seed_value,
    input  logic [4:0]                         bit_count,
    input  logic [lcg48br_pkg::DRAW_W-1:0]     bound,
    output logic                               done,
    output logic [lcg48br_pkg::DRAW_W-1:0]     value,
    output logic [lcg48br_pkg::SEED_W-1:0]     seed_after
);

    lcg48br_pkg::cmd_t    cmd;
    lcg48br_pkg::status_t status;

    // Sequence the request: advance, extract, divide, check, deliver
    lcg48br_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Hold the seed, the captured item and the remainder unit
    lcg48br_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .func       (func),
        .seed_value (seed_value),
        .bit_count  (bit_count),
        .bound      (bound),
        .status     (status),
        .value      (value),
        .seed_after (seed_after)
    );

endmodule

// ===== tb/lcg48_bounded_random_test.sv =====
module lcg48_bounded_random_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Code 3 has no name in the package; the block ignores it.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Cycles with neither an accepted item nor a result before giving up.
    // A rejected bounded draw repeats the seed advance and the division; this
    // limit covers well over a hundred back-to-back rejections.
    localparam int STALL_LIMIT = 5000;
    // Quiet cycles after the last result, longer than one full attempt.
    localparam int TAIL_CYCLES = 50;
    localparam int RANDOM_PER_PHASE = 210;
    localparam int NUM_PHASES = 3;
    localparam int NUM_DIRECTED = 25;

    // One request, plus an optional hand-typed expectation.
    typedef struct packed {
        logic [1:0]                     func;
        logic [63:0]                    seed_value;
        logic [4:0]                     bit_count;
        logic [lcg48br_pkg::DRAW_W-1:0] bound;
        logic                           fixed;
        logic [lcg48br_pkg::DRAW_W-1:0] fixed_value;
        logic [lcg48br_pkg::SEED_W-1:0] fixed_seed;
    } request_t;

    typedef struct packed {
        logic [lcg48br_pkg::DRAW_W-1:0] value;
        logic [lcg48br_pkg::SEED_W-1:0] seed;
    } draw_result_t;

    // Directed stimulus. Rows with fixed set carry a result that is plain
    // from the seed they start at; all others go through the predictor.
    localparam request_t DIRECTED [NUM_DIRECTED] = '{
        // ignored code right after reset: seed stays zero
        '{FUNC_UNUSED, 64'h0, 5'd31, 31'd5, 1'b1, 31'd0, 48'h0},
        // first raw draw from a zero seed: seed becomes the increment
        '{lcg48br_pkg::FUNC_RAW, 64'h0, 5'd31, 31'd0, 1'b1, 31'd0, 48'hB},
        '{lcg48br_pkg::FUNC_RESEED, 64'h0, 5'd0, 31'd0, 1'b1, 31'd0, 48'h5_DEEC_E66D},
        '{lcg48br_pkg::FUNC_RAW, 64'h0, 5'd31, 31'd0, 1'b0, 31'd0, 48'h0},
        // boolean draw
        '{lcg48br_pkg::FUNC_RAW, 64'h0, 5'd1, 31'd0, 1'b0, 31'd0, 48'h0},
        // zero bit count still advances the seed
        '{lcg48br_pkg::FUNC_RAW, 64'h0, 5'd0, 31'd0, 1'b0, 31'd0, 48'h0},
        '{lcg48br_pkg::FUNC_RAW, 64'h0, 5'd16, 31'd0, 1'b0, 31'd0, 48'h0},
        '{lcg48br_pkg::FUNC_RESEED, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 31'h7FFF_FFFF,
          1'b1, 31'd0, 48'hFFFA_2113_1992},
        '{lcg48br_pkg::FUNC_RAW, 64'h0, 5'd31, 31'd0, 1'b0, 31'd0, 48'h0},
        '{FUNC_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 31'h7FFF_FFFF,
          1'b0, 31'd0, 48'h0},
        // upper 16 seed bits must be dropped: seed lands on zero
        '{lcg48br_pkg::FUNC_RESEED, 64'hFFFF_0005_DEEC_E66D, 5'd0, 31'd0,
          1'b1, 31'd0, 48'h0},
        // zero bound counts as a power of two, value is zero
        '{lcg48br_pkg::FUNC_BOUNDED, 64'h0, 5'd0, 31'd0, 1'b1, 31'd0, 48'hB},
        '{lcg48br_pkg::FUNC_RESEED, 64'h5_DEEC_E66D, 5'd0, 31'd0, 1'b1, 31'd0, 48'h0},
        '{lcg48br_pkg::FUNC_RAW, 64'h0, 5'd0, 31'd0, 1'b1, 31'd0, 48'hB},
        '{lcg48br_pkg::FUNC_BOUNDED, 64'h0, 5'd0, 31'd1, 1'b0, 31'd0, 48'h0},
        '{lcg48br_pkg::FUNC_BOUNDED, 64'h0, 5'd0, 31'h4000_0000, 1'b0, 31'd0, 48'h0},
        // just past a power of two: rejection is most likely here
        '{lcg48br_pkg::FUNC_BOUNDED, 64'h0, 5'd0, 31'h4000_0001, 1'b0, 31'd0, 48'h0},
        '{lcg48br_pkg::FUNC_BOUNDED, 64'h0, 5'd0, 31'h7FFF_FFFF, 1'b0, 31'd0, 48'h0},
        '{lcg48br_pkg::FUNC_BOUNDED, 64'h0, 5'd0, 31'd3, 1'b0, 31'd0, 48'h0},
        '{lcg48br_pkg::FUNC_BOUNDED, 64'h0, 5'd0, 31'd10, 1'b0, 31'd0, 48'h0},
        '{lcg48br_pkg::FUNC_BOUNDED, 64'h0, 5'd0, 31'h5555_5555, 1'b0, 31'd0, 48'h0},
        '{lcg48br_pkg::FUNC_BOUNDED, 64'h0, 5'd0, 31'd2, 1'b0, 31'd0, 48'h0},
        '{lcg48br_pkg::FUNC_RESEED, 64'h0000_FFFF_FFFF_FFFF, 5'd0, 31'd0,
          1'b1, 31'd0, 48'hFFFA_2113_1992},
        '{lcg48br_pkg::FUNC_RAW, 64'h0, 5'd31, 31'd0, 1'b0, 31'd0, 48'h0},
        '{lcg48br_pkg::FUNC_BOUNDED, 64'h0, 5'd0, 31'h6000_0001, 1'b0, 31'd0, 48'h0}
    };

    // Sender idle percentage per random phase: none, heavy, light.
    localparam int PHASE_IDLE [NUM_PHASES] = '{0, 61, 6};

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [1:0]                     func = lcg48br_pkg::FUNC_RESEED;
    logic [63:0]                    seed_value = '0;
    logic [4:0]                     bit_count = '0;
    logic [lcg48br_pkg::DRAW_W-1:0] bound = '0;
    logic                           done;
    logic [lcg48br_pkg::DRAW_W-1:0] value;
    logic [lcg48br_pkg::SEED_W-1:0] seed_after;

    // Predictor state: the generator seed as the block should hold it.
    logic [lcg48br_pkg::SEED_W-1:0] model_seed = '0;
    draw_result_t      pending_draws[$];
    int                failures = 0;
    int                quiet_cycles = 0;

    lcg48_bounded_random DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .seed_value (seed_value),
        .bit_count  (bit_count),
        .bound      (bound),
        .done       (done),
        .value      (value),
        .seed_after (seed_after)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Advance the predicted seed once and return its top nbits bits.
    function automatic logic [31:0] take_bits(input int unsigned nbits);
        model_seed = model_seed * {13'd0, lcg48br_pkg::LCG_MULT} + lcg48br_pkg::LCG_INC;
        if (nbits == 0)
            return 32'd0;
        return 32'(model_seed >> (lcg48br_pkg::SEED_W - nbits));
    endfunction

    // Bounded draw: multiply and shift for a power of two (zero included),
    // otherwise take the remainder and redraw while the wrapped sum
    // bits - rem + n - 1 has its sign bit set.
    function automatic logic [31:0] draw_bounded(input logic [31:0] n);
        logic [63:0] product;
        logic [31:0] bits;
        logic [31:0] rem;
        if ((n & (n - 32'd1)) == 32'd0)
        begin
            product = {32'd0, n} * {32'd0, take_bits(lcg48br_pkg::DRAW_W)};
            return product[62:31];
        end
        do
        begin
            bits = take_bits(lcg48br_pkg::DRAW_W);
            rem  = bits % n;
        end while (((bits - rem + n - 32'd1) & 32'h8000_0000) != 32'd0);
        return rem;
    endfunction

    function automatic draw_result_t predict_draw(input request_t req);
        draw_result_t res;
        res.value = '0;
        case (req.func)
            lcg48br_pkg::FUNC_RESEED:
            begin
                model_seed = req.seed_value[lcg48br_pkg::SEED_W-1:0]
                           ^ {13'd0, lcg48br_pkg::LCG_MULT};
            end
            lcg48br_pkg::FUNC_RAW:
            begin
                res.value = lcg48br_pkg::DRAW_W'(take_bits(32'(req.bit_count)));
            end
            lcg48br_pkg::FUNC_BOUNDED:
            begin
                res.value = lcg48br_pkg::DRAW_W'(draw_bounded({1'b0, req.bound}));
            end
            default:      ;
        endcase
        res.seed = model_seed;
        return res;
    endfunction

    // Random request, weighted toward draws; every field is filled so all
    // input bits toggle even where the code ignores them.
    function automatic request_t random_request();
        request_t    req;
        int unsigned pick;
        req = '0;
        req.seed_value = {$urandom, $urandom};
        req.bit_count  = 5'($urandom);
        req.bound      = lcg48br_pkg::DRAW_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 12)
            req.func = lcg48br_pkg::FUNC_RESEED;
        else if (pick < 45)
            req.func = lcg48br_pkg::FUNC_RAW;
        else if (pick < 95)
            req.func = lcg48br_pkg::FUNC_BOUNDED;
        else
            req.func = FUNC_UNUSED;
        case ($urandom_range(5))
            0: req.seed_value = '0;
            1: req.seed_value = '1;
            default: ;
        endcase
        // Lean on the extreme bit counts.
        case ($urandom_range(3))
            0: req.bit_count = 5'd31;
            1: req.bit_count = 5'd1;
            default: ;
        endcase
        case ($urandom_range(4))
            0: req.bound = lcg48br_pkg::DRAW_W'($urandom_range(1, 100));
            1: req.bound = ($urandom_range(9) == 0) ? '0
                         : lcg48br_pkg::DRAW_W'(1)
                           << $urandom_range(0, lcg48br_pkg::DRAW_W - 1);
            2: req.bound = 31'h4000_0000
                         + lcg48br_pkg::DRAW_W'($urandom_range(1, 4096));
            3: req.bound = 31'h7FFF_FFFF
                         - lcg48br_pkg::DRAW_W'($urandom_range(0, 1000));
            default: ;
        endcase
        return req;
    endfunction

    function automatic void note_failure(input string msg);
        if (failures < 10)
            $display("%s", msg);
        failures++;
    endfunction

    // Drive one item at the falling edge, idling first at the given rate,
    // and hold it until an edge sees busy low. Predict at that edge.
    task automatic send_request(input request_t req, input int idle_pct);
        draw_result_t want;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start      <= 1'b1;
        func       <= req.func;
        seed_value <= req.seed_value;
        bit_count  <= req.bit_count;
        bound      <= req.bound;
        do
            @(posedge clk);
        while (busy);
        want = predict_draw(req);
        if (req.fixed)
        begin
            want.value = req.fixed_value;
            want.seed  = req.fixed_seed;
        end
        pending_draws.push_back(want);
    endtask

    // Drop start and hold off until every expected result is back.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
    endtask

    // Results can't be held off: take whatever is on the ports at each edge
    // where done was high and compare against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        draw_result_t want;
        if (rst_n && done)
        begin
            if (pending_draws.size() == 0)
                note_failure($sformatf("unexpected result: value %h seed %h",
                                       value, seed_after));
            else
            begin
                want = pending_draws.pop_front();
                if (value !== want.value || seed_after !== want.seed)
                    note_failure($sformatf(
                        "mismatch: expected value %h seed %h, got value %h seed %h",
                        want.value, want.seed, value, seed_after));
            end
        end
    end

    // Watchdog: count edges with no accepted item and no result.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no progress for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        // Hold reset, then release it on a falling edge.
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, back to back.
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_request(DIRECTED[i], 0);
        drain_results();

        // Random phases; between them the sender waits for every result.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_request(random_request(), PHASE_IDLE[p]);
            drain_results();
        end

        // Watch for stray results after the last expected one.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (failures == 0 && pending_draws.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
